[rtl/tetp_pkg.sv]
// Shared types, widths and constants of the positron trapping density block.
// Used by tetp_exp, tetp_div and the top level; depends on nothing else.
package tetp_pkg;

   // Field and register widths
   localparam int TIME_W  = 32;
   localparam int LIFE_W  = 24;
   localparam int TRAP_W  = 32;
   localparam int DENS_W  = 41;
   localparam int STAT_W  = 2;
   localparam int CSR_W   = 32;

   // Internal datapath widths
   localparam int RATE_W  = 41;   // Q9.32 rates up to 2^40 + 2^32
   localparam int EXP_W   = 33;   // exp(-x) in Q0.32, 1.0 included
   localparam int COEF_W  = 84;   // coefficient magnitudes, three 28-bit chunks
   localparam int CHUNK_W = 28;
   localparam int PROD_W  = 61;   // one chunk times one exponential
   localparam int TERM_W  = 117;  // coefficient times exponential
   localparam int SUM_W   = 118;  // signed sum of both terms
   localparam int DVD_W   = 85;   // sum magnitude after dropping 32 fraction bits
   localparam int QUOT_W  = 41;

   // Register cycles through the exponential unit
   localparam int EXP_LAT = 30;

   // ln 2 in Q.40 and 1.0 in Q0.32
   localparam logic [39:0] LN2_Q40 = 40'd762123384786;
   localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

   // ceil(2^36 / n) for n = 1 .. 12, exact floor division of 32-bit values
   localparam logic [36:0] TAYLOR_RECIP [12] = '{
      37'd68719476736, 37'd34359738368, 37'd22906492246, 37'd17179869184,
      37'd13743895348, 37'd11453246123, 37'd9817068106,  37'd8589934592,
      37'd7635497416,  37'd6871947674,  37'd6247225158,  37'd5726623062
   };

   // Register indexes of the configuration port
   localparam logic [1:0] CSR_BULK   = 2'd0;
   localparam logic [1:0] CSR_DEFECT = 2'd1;
   localparam logic [1:0] CSR_TRAP   = 2'd2;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NEG_TIME  = 2'd1,
      STATUS_BAD_PARAM = 2'd2
   } status_type;

   // Parameter setup sequencer
   typedef enum logic [2:0] {
      SEQ_START,
      SEQ_DIV_B,
      SEQ_DIV_D,
      SEQ_PREP,
      SEQ_MUL,
      SEQ_IDLE
   } seq_state_type;

   // Side information that travels with a word through the divider
   typedef struct packed {
      logic       valid;
      logic       rneg;
      status_type status;
   } tag_type;

endpackage

[rtl/tetp_exp.sv]
// Pipelined exp(-rate * t) in Q0.32: exponent product, ln 2 range reduction
// and a 12-term nested Taylor form. Depends on tetp_pkg.
module tetp_exp (
   input  logic                         clock,
   input  logic                         advance,
   input  logic [tetp_pkg::RATE_W-1:0]  rate,
   input  logic [30:0]                  t,
   output logic [tetp_pkg::EXP_W-1:0]   e
);

   localparam logic [44:0] LN2_X = 45'(tetp_pkg::LN2_Q40);

   // One restoring step against a shifted ln 2: quotient bit over remainder.
   function automatic logic [45:0] ln2_step(input logic [44:0] rem, input logic [44:0] lim);
      logic [45:0] res;
      if (rem >= lim) res = {1'b1, rem - lim};
      else res = {1'b0, rem};
      return res;
   endfunction

   logic [62:0] pp_lo_ff;
   logic [39:0] pp_hi_ff;
   logic [71:0] x_ff;
   logic [44:0] rem1_ff, rem2_ff, rem3_ff;
   logic [1:0]  m1_ff;
   logic [3:0]  m2_ff;
   logic [5:0]  m3_ff;
   logic        big1_ff, big2_ff, big3_ff;
   logic [45:0] s5, s4, s3, s2, s1, s0;

   logic [31:0] p_ff   [12];
   logic [31:0] r_a_ff [12];
   logic [31:0] r_b_ff [12];
   logic [5:0]  m_a_ff [12];
   logic [5:0]  m_b_ff [12];
   logic        big_a_ff [12];
   logic        big_b_ff [12];
   logic [32:0] h_ff   [12];
   logic [tetp_pkg::EXP_W-1:0] e_in, e_ff;

   // Exponent product in two partial products, then their sum.
   always_ff @(posedge clock) begin
      if (advance) begin
         pp_lo_ff <= 63'(rate[31:0]) * 63'(t);
         pp_hi_ff <= 40'(rate[40:32]) * 40'(t);
         x_ff     <= 72'(pp_lo_ff) + (72'(pp_hi_ff) << 32);
      end
   end

   // Range reduction by ln 2, two quotient bits per stage.
   assign s5 = ln2_step(x_ff[44:0], LN2_X << 5);
   assign s4 = ln2_step(s5[44:0], LN2_X << 4);
   assign s3 = ln2_step(rem1_ff, LN2_X << 3);
   assign s2 = ln2_step(s3[44:0], LN2_X << 2);
   assign s1 = ln2_step(rem2_ff, LN2_X << 1);
   assign s0 = ln2_step(s1[44:0], LN2_X);

   always_ff @(posedge clock) begin
      if (advance) begin
         rem1_ff <= s4[44:0];
         m1_ff   <= {s5[45], s4[45]};
         big1_ff <= |x_ff[71:45];
         rem2_ff <= s2[44:0];
         m2_ff   <= {m1_ff, s3[45], s2[45]};
         big2_ff <= big1_ff;
         rem3_ff <= s0[44:0];
         m3_ff   <= {m2_ff, s1[45], s0[45]};
         big3_ff <= big2_ff;
      end
   end

   // Nested Taylor form, one multiply stage and one divide-by-n stage per term.
   for (genvar i = 0; i < 12; i++) begin : g_tay
      logic [31:0] r_in;
      logic [32:0] h_in;
      logic [5:0]  m_in;
      logic        big_in;
      logic [64:0] rh;
      logic [68:0] pq;

      if (i == 0) begin : g_first
         assign r_in   = rem3_ff[39:8];
         assign h_in   = tetp_pkg::ONE_Q32;
         assign m_in   = m3_ff;
         assign big_in = big3_ff;
      end else begin : g_next
         assign r_in   = r_b_ff[i-1];
         assign h_in   = h_ff[i-1];
         assign m_in   = m_b_ff[i-1];
         assign big_in = big_b_ff[i-1];
      end

      assign rh = 65'(r_in) * 65'(h_in);
      assign pq = 69'(p_ff[i]) * 69'(tetp_pkg::TAYLOR_RECIP[11-i]);

      always_ff @(posedge clock) begin
         if (advance) begin
            p_ff[i]     <= rh[63:32];
            r_a_ff[i]   <= r_in;
            m_a_ff[i]   <= m_in;
            big_a_ff[i] <= big_in;
            h_ff[i]     <= tetp_pkg::ONE_Q32 - {1'b0, pq[67:36]};
            r_b_ff[i]   <= r_a_ff[i];
            m_b_ff[i]   <= m_a_ff[i];
            big_b_ff[i] <= big_a_ff[i];
         end
      end
   end

   // Scale by 2^-m; an exponent of 32 or more gives zero.
   assign e_in = big_b_ff[11] ? '0 : (h_ff[11] >> m_b_ff[11]);

   always_ff @(posedge clock) begin
      if (advance) e_ff <= e_in;
   end

   assign e = e_ff;

endmodule

[rtl/tetp_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Carries a tag with each word. Depends on tetp_pkg.
module tetp_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  tetp_pkg::tag_type             tag_in,
   input  logic [tetp_pkg::DVD_W-1:0]    dividend,
   input  logic [tetp_pkg::QUOT_W-1:0]   divisor,
   output tetp_pkg::tag_type             tag_out,
   output logic                          over,
   output logic [tetp_pkg::QUOT_W-1:0]   quot
);

   localparam int QW = tetp_pkg::QUOT_W;
   localparam int NS = tetp_pkg::QUOT_W + 1;

   tetp_pkg::tag_type tag_ff [NS];
   logic              over_ff [NS];
   logic [QW-1:0]     rem_ff  [NS];
   logic [QW-1:0]     low_ff  [NS];
   logic [QW-1:0]     q_ff    [NS];

   // Entry stage: a quotient of 2^41 or more is flagged as overflow.
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff[0] <= '0;
      end else if (advance) begin
         tag_ff[0] <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         over_ff[0] <= dividend[tetp_pkg::DVD_W-1:QW] >= (tetp_pkg::DVD_W-QW)'(divisor);
         rem_ff[0]  <= dividend[2*QW-1:QW];
         low_ff[0]  <= dividend[QW-1:0];
         q_ff[0]    <= '0;
      end
   end

   // One quotient bit per stage.
   for (genvar i = 1; i < NS; i++) begin : g_step
      logic [QW:0] trial;
      logic [QW:0] diff;
      logic        ge;

      assign trial = {rem_ff[i-1], low_ff[i-1][QW-1]};
      assign diff  = trial - {1'b0, divisor};
      assign ge    = trial >= {1'b0, divisor};

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[i] <= '0;
         end else if (advance) begin
            tag_ff[i] <= tag_ff[i-1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            over_ff[i] <= over_ff[i-1];
            rem_ff[i]  <= ge ? diff[QW-1:0] : trial[QW-1:0];
            low_ff[i]  <= {low_ff[i-1][QW-2:0], 1'b0};
            q_ff[i]    <= {q_ff[i-1][QW-2:0], ge};
         end
      end
   end

   assign tag_out = tag_ff[NS-1];
   assign over    = over_ff[NS-1];
   assign quot    = q_ff[NS-1];

endmodule

[rtl/two_exponential_trapping_pdf_top.sv]
// Top level of the one-defect positron trapping lifetime density block.
// Depends on tetp_pkg, tetp_exp and tetp_div.
//
// Usage:
//   The req_ channel carries one time sample (signed Q24.8) per word. The rsp_
//   channel returns one word per sample: the density (signed Q9.32,
//   saturating) in rsp_tdata and the status code in rsp_tuser.
//   The csr_ port writes bulk lifetime, defect lifetime and trapping rate.
//   After reset and after every register write, a setup sequencer forms the
//   two rates, the denominator and both term coefficients with a bit-serial
//   divider and a shift-add multiplier; req_tready is low while it runs.
//   An accepted sample passes the input register, exponential units, term
//   products, sum, divider and output register. Throughput is one sample
//   per cycle outside setup and stalls: two exponential units, the term
//   multipliers and a 42-stage divider are all fully pipelined.
//   When the receiver stalls, the whole pipeline holds and req_tready drops
//   until the output register is taken; nothing is lost or repeated.
module two_exponential_trapping_pdf_top (
   input  logic        clock,
   input  logic        reset,
   // input words, tdata: time_sample[31:0]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // result words, tdata: density[40:0], zero fill [47:41]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   // tuser: status[1:0]
   output logic [1:0]  rsp_tuser,
   // configuration writes
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int RW  = tetp_pkg::RATE_W;
   localparam int LW  = tetp_pkg::LIFE_W;
   localparam int CW  = tetp_pkg::CHUNK_W;
   localparam int LAT = tetp_pkg::EXP_LAT;

   // Configuration registers
   logic [LW-1:0]               bulk_ff, defect_ff;
   logic [tetp_pkg::TRAP_W-1:0] trap_ff;

   // Setup sequencer
   tetp_pkg::seq_state_type state_ff, state_in;
   logic [LW-1:0] rem_ff;
   logic [RW-1:0] dvd_ff, quo_ff;
   logic [5:0]    cnt_ff;
   logic [LW-1:0] tau_sel;
   logic [LW:0]   trial, diff;
   logic          ge;
   logic [RW-1:0] quo_next;
   logic [RW-1:0] lb_ff, ld_ff, r1_ff, dmag_ff;
   logic          dneg_ff, c1neg_ff, invalid_ff;
   logic [RW:0]   den, num;
   logic [RW-1:0] r1;
   logic [81:0]   acc1_ff, mc1_ff;
   logic [71:0]   acc2_ff, mc2_ff;
   logic [RW-1:0] mp1_ff;
   logic [31:0]   mp2_ff;

   // Pipeline
   logic          advance;
   logic [31:0]   time_ff;
   logic          meta_valid_ff [LAT+1];
   logic          meta_neg_ff   [LAT+1];
   logic [tetp_pkg::EXP_W-1:0] e1, e2;
   logic [tetp_pkg::COEF_W-1:0] coef1, coef2;
   logic [tetp_pkg::PROD_W-1:0] pp10_ff, pp11_ff, pp12_ff, pp20_ff, pp21_ff, pp22_ff;
   logic [tetp_pkg::TERM_W-1:0] t1_ff, t2_ff;
   logic [tetp_pkg::SUM_W-1:0]  sum_ff, s1, smag;
   logic          v1_ff, v2_ff, v3_ff, n1_ff, n2_ff, n3_ff;
   tetp_pkg::tag_type           tag_in, tag_out;
   logic [tetp_pkg::DVD_W-1:0]  dvd_in;
   logic          over;
   logic [tetp_pkg::QUOT_W-1:0] quot;
   logic          rsp_valid_ff;
   logic [tetp_pkg::DENS_W-1:0] density_ff, density_in, mag;
   tetp_pkg::status_type        status_ff;

   // Register writes; out-of-range indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         bulk_ff   <= 24'd256;
         defect_ff <= 24'd512;
         trap_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            tetp_pkg::CSR_BULK:   bulk_ff   <= csr_wdata[LW-1:0];
            tetp_pkg::CSR_DEFECT: defect_ff <= csr_wdata[LW-1:0];
            tetp_pkg::CSR_TRAP:   trap_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer state register.
   always_ff @(posedge clock) begin
      if (reset) state_ff <= tetp_pkg::SEQ_START;
      else state_ff <= state_in;
   end

   // Sequencer next state; any write restarts the setup.
   always_comb begin
      state_in = state_ff;
      if (csr_we) begin
         state_in = tetp_pkg::SEQ_START;
      end else begin
         unique case (state_ff)
            tetp_pkg::SEQ_START: state_in = tetp_pkg::SEQ_DIV_B;
            tetp_pkg::SEQ_DIV_B: if (cnt_ff == 6'd0) state_in = tetp_pkg::SEQ_DIV_D;
            tetp_pkg::SEQ_DIV_D: if (cnt_ff == 6'd0) state_in = tetp_pkg::SEQ_PREP;
            tetp_pkg::SEQ_PREP:  state_in = tetp_pkg::SEQ_MUL;
            tetp_pkg::SEQ_MUL:   if (cnt_ff == 6'd0) state_in = tetp_pkg::SEQ_IDLE;
            tetp_pkg::SEQ_IDLE:  state_in = tetp_pkg::SEQ_IDLE;
            default:             state_in = tetp_pkg::SEQ_START;
         endcase
      end
   end

   // Bit-serial rate division: round(2^40 / tau), one quotient bit a cycle.
   assign tau_sel  = (state_ff == tetp_pkg::SEQ_DIV_D) ? defect_ff : bulk_ff;
   assign trial    = {rem_ff, dvd_ff[RW-1]};
   assign diff     = trial - {1'b0, tau_sel};
   assign ge       = trial >= {1'b0, tau_sel};
   assign quo_next = {quo_ff[RW-2:0], ge};

   // Derived rates, denominator and numerator from the two divided rates.
   assign r1  = lb_ff + RW'(trap_ff);
   assign den = {1'b0, r1} - {1'b0, ld_ff};
   assign num = {1'b0, lb_ff} - {1'b0, ld_ff};

   // Sequencer datapath.
   always_ff @(posedge clock) begin
      case (state_ff)
         tetp_pkg::SEQ_START: begin
            rem_ff <= '0;
            dvd_ff <= (RW'(1) << 40) + RW'(bulk_ff >> 1);
            cnt_ff <= 6'd40;
         end
         tetp_pkg::SEQ_DIV_B, tetp_pkg::SEQ_DIV_D: begin
            if (cnt_ff == 6'd0) begin
               if (state_ff == tetp_pkg::SEQ_DIV_B) lb_ff <= quo_next;
               else ld_ff <= quo_next;
               rem_ff <= '0;
               dvd_ff <= (RW'(1) << 40) + RW'(defect_ff >> 1);
               cnt_ff <= 6'd40;
            end else begin
               rem_ff <= ge ? diff[LW-1:0] : trial[LW-1:0];
               dvd_ff <= {dvd_ff[RW-2:0], 1'b0};
               cnt_ff <= cnt_ff - 6'd1;
            end
            quo_ff <= quo_next;
         end
         tetp_pkg::SEQ_PREP: begin
            r1_ff      <= r1;
            dneg_ff    <= den[RW];
            dmag_ff    <= den[RW] ? RW'(-den) : den[RW-1:0];
            c1neg_ff   <= num[RW];
            invalid_ff <= (bulk_ff == '0) || (defect_ff == '0) || (den == '0);
            mc1_ff     <= 82'(r1);
            mp1_ff     <= num[RW] ? RW'(-num) : num[RW-1:0];
            mc2_ff     <= 72'(ld_ff);
            mp2_ff     <= trap_ff;
            acc1_ff    <= '0;
            acc2_ff    <= '0;
            cnt_ff     <= 6'd40;
         end
         tetp_pkg::SEQ_MUL: begin
            if (mp1_ff[0]) acc1_ff <= acc1_ff + mc1_ff;
            if (mp2_ff[0]) acc2_ff <= acc2_ff + mc2_ff;
            mc1_ff <= {mc1_ff[80:0], 1'b0};
            mc2_ff <= {mc2_ff[70:0], 1'b0};
            mp1_ff <= mp1_ff >> 1;
            mp2_ff <= mp2_ff >> 1;
            cnt_ff <= cnt_ff - 6'd1;
         end
         default: ;
      endcase
   end

   // Whole pipeline moves when the output register is free or being taken.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance && (state_ff == tetp_pkg::SEQ_IDLE);

   // Input register and side information alongside the exponential units.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LAT; i++) meta_valid_ff[i] <= 1'b0;
      end else if (advance) begin
         meta_valid_ff[0] <= req_tvalid && req_tready;
         for (int i = 1; i <= LAT; i++) meta_valid_ff[i] <= meta_valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         time_ff        <= req_tdata;
         meta_neg_ff[0] <= req_tdata[31];
         for (int i = 1; i <= LAT; i++) meta_neg_ff[i] <= meta_neg_ff[i-1];
      end
   end

   // Two decaying exponentials: total rate and defect rate.
   tetp_exp u_exp_fast (
      .clock   (clock),
      .advance (advance),
      .rate    (r1_ff),
      .t       (time_ff[30:0]),
      .e       (e1)
   );

   tetp_exp u_exp_defect (
      .clock   (clock),
      .advance (advance),
      .rate    (ld_ff),
      .t       (time_ff[30:0]),
      .e       (e2)
   );

   // Coefficient times exponential as three chunk products per term.
   assign coef1 = {2'b0, acc1_ff};
   assign coef2 = {12'b0, acc2_ff};

   always_ff @(posedge clock) begin
      if (advance) begin
         pp10_ff <= 61'(coef1[CW-1:0])      * 61'(e1);
         pp11_ff <= 61'(coef1[2*CW-1:CW])   * 61'(e1);
         pp12_ff <= 61'(coef1[3*CW-1:2*CW]) * 61'(e1);
         pp20_ff <= 61'(coef2[CW-1:0])      * 61'(e2);
         pp21_ff <= 61'(coef2[2*CW-1:CW])   * 61'(e2);
         pp22_ff <= 61'(coef2[3*CW-1:2*CW]) * 61'(e2);
         t1_ff   <= 117'(pp10_ff) + (117'(pp11_ff) << CW) + (117'(pp12_ff) << (2 * CW));
         t2_ff   <= 117'(pp20_ff) + (117'(pp21_ff) << CW) + (117'(pp22_ff) << (2 * CW));
         sum_ff  <= s1 + 118'(t2_ff);
      end
   end

   // The first term carries the sign of the rate difference.
   assign s1   = c1neg_ff ? (118'(0) - 118'(t1_ff)) : 118'(t1_ff);
   assign smag = sum_ff[117] ? (118'(0) - sum_ff) : sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= meta_valid_ff[LAT];
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         n1_ff <= meta_neg_ff[LAT];
         n2_ff <= n1_ff;
         n3_ff <= n2_ff;
      end
   end

   // Divider input: magnitude without its 32 fraction bits, and the status.
   always_comb begin
      tag_in.valid = v3_ff;
      tag_in.rneg  = sum_ff[117] ^ dneg_ff;
      if (n3_ff) tag_in.status = tetp_pkg::STATUS_NEG_TIME;
      else if (invalid_ff) tag_in.status = tetp_pkg::STATUS_BAD_PARAM;
      else tag_in.status = tetp_pkg::STATUS_OK;
   end

   assign dvd_in = smag[116:32];

   tetp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .tag_in   (tag_in),
      .dividend (dvd_in),
      .divisor  (dmag_ff),
      .tag_out  (tag_out),
      .over     (over),
      .quot     (quot)
   );

   // Saturation to [-2^40, 2^40 - 1]; special cases give zero.
   always_comb begin
      mag = quot;
      if (tag_out.status != tetp_pkg::STATUS_OK) begin
         density_in = '0;
      end else if (tag_out.rneg) begin
         if (over || (quot > (41'd1 << 40))) mag = 41'd1 << 40;
         density_in = 41'd0 - mag;
      end else begin
         density_in = (over || quot[40]) ? {1'b0, {40{1'b1}}} : quot;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= tag_out.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         density_ff <= density_in;
         status_ff  <= tag_out.status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, density_ff};
   assign rsp_tuser  = status_ff;

endmodule
